[rtl/itoa_pkg.sv]
// itoa_pkg: shared types, constants and helpers for the integer to ascii unit
`timescale 1ns / 1ps

package itoa_pkg;

    // field widths of the words on the ports
    localparam int VALUE_W  = 32;
    localparam int BASE_W   = 6;
    localparam int CHAR_W   = 7;
    localparam int LENGTH_W = 6;
    localparam int DIGIT_W  = 6;

    // radix limits and the signed radix
    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
    localparam logic [BASE_W-1:0] TEN      = 6'd10;

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;

    // input word
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [BASE_W-1:0]         base;
    } itoa_in_t;

    // result word
    typedef struct packed {
        logic [CHAR_W-1:0]   character;
        logic                last;
        logic [LENGTH_W-1:0] length;
        logic                bad_base;
    } itoa_out_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_PUSH,
        ST_SIGN,
        ST_EMIT,
        ST_BAD
    } itoa_state_t;

    // which kind of result the datapath drives
    typedef enum logic [1:0] {
        OUT_SIGN,
        OUT_DIGIT,
        OUT_BAD
    } itoa_out_sel_t;

    // commands from the controller
    typedef struct packed {
        logic          load;
        logic          step;
        logic          push;
        logic          pop;
        itoa_out_sel_t out_sel;
    } itoa_cmd_t;

    // status back to the controller
    typedef struct packed {
        logic bad_base;
        logic minus;
        logic step_last;
        logic quo_zero;
        logic last_digit;
    } itoa_sts_t;

    // digit value to its ascii character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {1'b0, d};
        if (d < DIGIT_W'(TEN))
            return d_ext + CHAR_ZERO;
        else
            return d_ext - CHAR_W'(TEN) + CHAR_A;
    endfunction

endpackage

[rtl/itoa_ctrl.sv]
// itoa_ctrl: sequencing state machine for load, divide, push and emit
`timescale 1ns / 1ps

module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      strobe,
    output itoa_cmd_t cmd,
    input  itoa_sts_t sts
);

    itoa_state_t state_reg;
    itoa_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = sts.bad_base ? ST_BAD : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (sts.step_last)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!sts.quo_zero)
                    state_next = ST_DIVIDE;
                else if (sts.minus)
                    state_next = ST_SIGN;
                else
                    state_next = ST_EMIT;
            end
            ST_SIGN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.last_digit)
                    state_next = ST_IDLE;
            end
            ST_BAD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        busy        = 1'b1;
        strobe      = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.push    = 1'b0;
        cmd.pop     = 1'b0;
        cmd.out_sel = OUT_DIGIT;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_CHECK:
            begin
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
            end
            ST_SIGN:
            begin
                strobe      = 1'b1;
                cmd.out_sel = OUT_SIGN;
            end
            ST_EMIT:
            begin
                strobe  = 1'b1;
                cmd.pop = 1'b1;
            end
            ST_BAD:
            begin
                strobe      = 1'b1;
                cmd.out_sel = OUT_BAD;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

[rtl/itoa_datapath.sv]
// itoa_datapath: bit-serial divider, digit stack and result formatting
`timescale 1ns / 1ps

module itoa_datapath
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  itoa_in_t  operand,
    input  itoa_cmd_t cmd,
    output itoa_sts_t sts,
    output itoa_out_t result
);

    localparam int STEP_W  = $clog2(VALUE_BITS);
    localparam int DEPTH_W = $clog2(VALUE_BITS + 1);
    localparam int SUM_W   = $clog2(VALUE_BITS + 2);
    localparam int LEN_XW  = (SUM_W > LENGTH_W) ? SUM_W : LENGTH_W;

    // payload registers
    logic [VALUE_BITS-1:0] quo_reg;
    logic [VALUE_BITS-1:0] quo_next;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [DIGIT_W-1:0]    rem_next;
    logic [BASE_W-1:0]     base_reg;
    logic                  minus_reg;
    logic                  bad_reg;
    logic [DIGIT_W-1:0]    stack_reg [VALUE_BITS];

    // control counters
    logic [STEP_W-1:0]  step_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] digits_reg;

    // load side
    logic [VALUE_BITS+VALUE_W-1:0] value_ext;
    logic [VALUE_BITS-1:0]         value_in;
    logic                          minus_in;
    logic                          bad_in;

    // divider step
    logic [DIGIT_W:0] trial;
    logic [DIGIT_W:0] diff;
    logic             fits;

    // length
    logic [LEN_XW-1:0] len_wide;

    // operand shaping and sign handling
    always_comb
    begin
        value_ext = {{VALUE_BITS{1'b0}}, operand.value};
        value_in  = value_ext[VALUE_BITS-1:0];
        bad_in    = (operand.base < BASE_MIN) || (operand.base > BASE_MAX);
        minus_in  = (operand.base == TEN) && value_in[VALUE_BITS-1];
    end

    // one restoring division step
    always_comb
    begin
        trial = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff  = trial - {1'b0, base_reg};
        fits  = trial >= {1'b0, base_reg};
    end

    // next divider state
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (cmd.load)
        begin
            quo_next = minus_in ? (~value_in + VALUE_BITS'(1)) : value_in;
            rem_next = '0;
        end
        else if (cmd.step)
        begin
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            rem_next = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        end
        else if (cmd.push)
        begin
            rem_next = '0;
        end
    end

    // divider and operand registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            base_reg  <= operand.base;
            minus_reg <= minus_in;
            bad_reg   <= bad_in;
        end
    end

    // digit stack, top at entry zero
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_reg[0] <= rem_reg;
            for (int i = 1; i < VALUE_BITS; i++)
                stack_reg[i] <= stack_reg[i-1];
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < VALUE_BITS - 1; i++)
                stack_reg[i] <= stack_reg[i+1];
        end
    end

    // step, depth and digit counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            depth_reg  <= '0;
            digits_reg <= '0;
        end
        else if (cmd.load)
        begin
            step_reg   <= '0;
            depth_reg  <= '0;
            digits_reg <= '0;
        end
        else if (cmd.step)
        begin
            step_reg <= step_reg + STEP_W'(1);
        end
        else if (cmd.push)
        begin
            step_reg   <= '0;
            depth_reg  <= depth_reg + DEPTH_W'(1);
            digits_reg <= digits_reg + DEPTH_W'(1);
        end
        else if (cmd.pop)
        begin
            depth_reg <= depth_reg - DEPTH_W'(1);
        end
    end

    // status to the controller
    always_comb
    begin
        sts.bad_base   = bad_reg;
        sts.minus      = minus_reg;
        sts.step_last  = (step_reg == STEP_W'(VALUE_BITS - 1));
        sts.quo_zero   = (quo_reg == '0);
        sts.last_digit = (depth_reg == DEPTH_W'(1));
    end

    // result word
    always_comb
    begin
        len_wide = LEN_XW'(digits_reg) + LEN_XW'(minus_reg);
        unique case (cmd.out_sel)
            OUT_SIGN:
            begin
                result.character = CHAR_MINUS;
                result.last      = 1'b0;
                result.length    = len_wide[LENGTH_W-1:0];
                result.bad_base  = 1'b0;
            end
            OUT_DIGIT:
            begin
                result.character = digit_char(stack_reg[0]);
                result.last      = (depth_reg == DEPTH_W'(1));
                result.length    = len_wide[LENGTH_W-1:0];
                result.bad_base  = 1'b0;
            end
            OUT_BAD:
            begin
                result.character = CHAR_NUL;
                result.last      = 1'b1;
                result.length    = '0;
                result.bad_base  = 1'b1;
            end
            default:
            begin
                result.character = CHAR_NUL;
                result.last      = 1'b0;
                result.length    = '0;
                result.bad_base  = 1'b0;
            end
        endcase
    end

endmodule

[rtl/integer_to_ascii_any_base_unit.sv]
// integer_to_ascii_any_base_unit: top level of the integer to ascii text converter
`timescale 1ns / 1ps
//
// usage
// - drive operand (value, base) and raise start; the word is taken on a rising
//   edge where start is high and busy is low
// - the text comes back one character per word on result, most significant
//   digit first, each word marked by strobe for exactly one cycle
// - base ten negatives lead with a minus; other bases convert the unsigned
//   two's complement pattern; a base outside 2..36 gives one word with bad_base
// - length on every word is the total character count; last marks the final word
// - sequence: one check step, then per digit a pass of the bit-serial divider
//   and a push, then one output word per cycle, the minus word first
// - the divide passes run at the pace of the one-bit-per-cycle restoring divider;
//   a bad base keeps busy high through the check and the bad word; the next
//   word can be taken as soon as busy is low again
// - busy stays high from acceptance until the final word has been shown
// - the receiver cannot hold words off, so there is no stall handling
// - reset returns the controller to idle and clears the counters
//
module integer_to_ascii_any_base_unit
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  itoa_in_t  operand,
    output logic      strobe,
    output itoa_out_t result
);

    itoa_cmd_t cmd;
    itoa_sts_t sts;

    // controller
    itoa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .strobe (strobe),
        .cmd    (cmd),
        .sts    (sts)
    );

    // datapath
    itoa_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result)
    );

endmodule
